FILE: design/blr_pkg.sv
package blr_pkg;

    localparam int TILE_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int KIND_W    = 2;
    localparam int ERR_W     = COORD_W + 3;

    localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(TILE_SIZE - 1);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [KIND_W-1:0]  kind_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } blr_state_t;

    typedef struct packed
    {
        logic load;
        logic step;
    } blr_cmd_t;

    typedef struct packed
    {
        logic last;
    } blr_status_t;

    function automatic coord_t clamp_coord(input coord_t v);
        coord_t c;
        c = (v > MAX_COORD) ? MAX_COORD : v;
        return c;
    endfunction

endpackage

FILE: design/blr_if.sv
interface blr_line_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    kind_t  fill_kind;

    modport source (output valid, start_x, start_y, end_x, end_y, fill_kind, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, fill_kind, output ready);
endinterface

interface blr_pixel_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    kind_t  paint_kind;
    logic   last;

    modport source (output valid, pixel_x, pixel_y, paint_kind, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, paint_kind, last, output ready);
endinterface

FILE: design/bresenham_line_rasterizer_top.sv
// channel  dir  fields                                        beat
// line     in   start_x, start_y, end_x, end_y, fill_kind      one line
// pixel    out  pixel_x, pixel_y, paint_kind, last             one pixel
//
// A line is taken, then the block emits major+1 pixels, one per cycle while
// pixel.ready is high (1 to 64 beats).
// The pixel beat comes straight from the datapath registers; a pixel stall holds them.
// The next line is taken only once the last pixel beat has gone.
// rst_n is asynchronous and returns the controller to idle.
module bresenham_line_rasterizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    blr_line_if.sink    line,
    blr_pixel_if.source pixel
);
    import blr_pkg::*;

    blr_cmd_t    cmd;
    blr_status_t status;

    blr_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_valid  (line.valid),
        .line_ready  (line.ready),
        .pixel_valid (pixel.valid),
        .pixel_ready (pixel.ready),
        .status      (status),
        .cmd         (cmd)
    );

    blr_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .start_x    (line.start_x),
        .start_y    (line.start_y),
        .end_x      (line.end_x),
        .end_y      (line.end_y),
        .fill_kind  (line.fill_kind),
        .pixel_x    (pixel.pixel_x),
        .pixel_y    (pixel.pixel_y),
        .paint_kind (pixel.paint_kind)
    );

    assign pixel.last = status.last;

endmodule

FILE: design/blr_ctrl.sv
module blr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 line_valid,
    output logic                 line_ready,
    output logic                 pixel_valid,
    input  logic                 pixel_ready,
    input  blr_pkg::blr_status_t status,
    output blr_pkg::blr_cmd_t    cmd
);
    import blr_pkg::*;

    blr_state_t state_reg;
    blr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        line_ready  = 1'b0;
        pixel_valid = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                line_ready = 1'b1;
                cmd.load   = line_valid;
                if (line_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                pixel_valid = 1'b1;
                cmd.step    = pixel_ready;
                if (pixel_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.last) |=> (state_reg == ST_IDLE))
        else $error("line did not end after last beat");

    a_no_load_while_run: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.step))
        else $error("load and step together");
`endif

endmodule

FILE: design/blr_datapath.sv
module blr_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  blr_pkg::blr_cmd_t    cmd,
    output blr_pkg::blr_status_t status,
    input  blr_pkg::coord_t      start_x,
    input  blr_pkg::coord_t      start_y,
    input  blr_pkg::coord_t      end_x,
    input  blr_pkg::coord_t      end_y,
    input  blr_pkg::kind_t       fill_kind,
    output blr_pkg::coord_t      pixel_x,
    output blr_pkg::coord_t      pixel_y,
    output blr_pkg::kind_t       paint_kind
);
    import blr_pkg::*;

    coord_t                   x_reg, x_next;
    coord_t                   y_reg, y_next;
    kind_t                    kind_reg, kind_next;
    logic                     sx_pos_reg, sx_pos_next;
    logic                     sy_pos_reg, sy_pos_next;
    logic                     xmaj_reg, xmaj_next;
    coord_t                   major_reg, major_next;
    coord_t                   minor_reg, minor_next;
    coord_t                   remain_reg, remain_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;

    coord_t                   xa, ya, xb, yb;
    logic signed [COORD_W:0]  dx, dy;
    coord_t                   adx, ady;
    logic signed [ERR_W-1:0]  err_add;
    logic signed [ERR_W:0]    err_dbl;
    logic                     hit;
    coord_t                   x_step, y_step;

    always_comb
    begin
        xa  = clamp_coord(start_x);
        ya  = clamp_coord(start_y);
        xb  = clamp_coord(end_x);
        yb  = clamp_coord(end_y);
        dx  = $signed({1'b0, xb}) - $signed({1'b0, xa});
        dy  = $signed({1'b0, yb}) - $signed({1'b0, ya});
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

        err_add = err_reg + $signed({{(ERR_W-COORD_W){1'b0}}, minor_reg});
        err_dbl = {err_add, 1'b0};
        hit     = err_dbl >= $signed({{(ERR_W+1-COORD_W){1'b0}}, major_reg});
        x_step  = sx_pos_reg ? (x_reg + COORD_W'(1)) : (x_reg - COORD_W'(1));
        y_step  = sy_pos_reg ? (y_reg + COORD_W'(1)) : (y_reg - COORD_W'(1));

        x_next      = x_reg;
        y_next      = y_reg;
        kind_next   = kind_reg;
        sx_pos_next = sx_pos_reg;
        sy_pos_next = sy_pos_reg;
        xmaj_next   = xmaj_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        remain_next = remain_reg;
        err_next    = err_reg;

        if (cmd.load)
        begin
            x_next      = xa;
            y_next      = ya;
            kind_next   = fill_kind;
            sx_pos_next = xb > xa;
            sy_pos_next = yb > ya;
            xmaj_next   = adx > ady;
            major_next  = (adx > ady) ? adx : ady;
            minor_next  = (adx > ady) ? ady : adx;
            remain_next = (adx > ady) ? adx : ady;
            err_next    = '0;
        end
        else if (cmd.step)
        begin
            remain_next = remain_reg - COORD_W'(1);
            err_next    = hit ? (err_add - $signed({{(ERR_W-COORD_W){1'b0}}, major_reg}))
                              : err_add;
            if (xmaj_reg)
            begin
                x_next = x_step;
                y_next = hit ? y_step : y_reg;
            end
            else
            begin
                y_next = y_step;
                x_next = hit ? x_step : x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            kind_reg   <= '0;
            sx_pos_reg <= 1'b0;
            sy_pos_reg <= 1'b0;
            xmaj_reg   <= 1'b0;
            major_reg  <= '0;
            minor_reg  <= '0;
            remain_reg <= '0;
            err_reg    <= '0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            kind_reg   <= kind_next;
            sx_pos_reg <= sx_pos_next;
            sy_pos_reg <= sy_pos_next;
            xmaj_reg   <= xmaj_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

    assign status.last = (remain_reg == '0);
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign paint_kind  = kind_reg;

`ifndef SYNTHESIS
    a_remain_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !status.last) |=> (remain_reg == $past(remain_reg) - COORD_W'(1)))
        else $error("pixel counter did not count down");

    a_major_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !status.last) |=>
            ((xmaj_reg && x_reg != $past(x_reg)) || (!xmaj_reg && y_reg != $past(y_reg))))
        else $error("major coordinate did not move");
`endif

endmodule
